/* sv/y2r_pkg.sv */
package y2r_pkg;

  // colour matrix codes
  typedef enum logic [1:0] {
    MAT_GBR    = 2'd0,
    MAT_BT709  = 2'd1,
    MAT_BT2020 = 2'd2,
    MAT_BT601  = 2'd3
  } matrix_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MATRIX   = 3'd0,
    REG_FULL     = 3'd1,
    REG_SHIFT    = 3'd2,
    REG_SWAP     = 3'd3,
    REG_ALPHA_EN = 3'd4
  } reg_idx_e;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ShiftW  = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 4;

  typedef struct packed {
    matrix_e           matrix;
    logic              full_swing;
    logic [ShiftW-1:0] shift;
    logic              swap_rb;
    logic              alpha_en;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] luma;
    logic [SampleW-1:0] cb;
    logic [SampleW-1:0] cr;
    logic [SampleW-1:0] alpha;
    logic               alpha_present;
  } pix_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] fourth;
  } rgba_t;

  typedef struct packed {
    logic signed [15:0] kr;
    logic signed [15:0] kg1;
    logic signed [15:0] kg2;
    logic signed [15:0] kb;
  } coef_t;

  function automatic coef_t coef_lookup(matrix_e m, logic full);
    coef_t k;
    k = '0;
    unique case (m)
      MAT_BT709: begin
        if (full) begin
          k.kr = 16'sd403;    k.kg1 = -16'sd48;   k.kg2 = -16'sd120;  k.kb = 16'sd475;
        end else begin
          k.kr = 16'sd14744;  k.kg1 = -16'sd1754; k.kg2 = -16'sd4383; k.kb = 16'sd17373;
        end
      end
      MAT_BT2020: begin
        if (full) begin
          k.kr = 16'sd377;    k.kg1 = -16'sd42;   k.kg2 = -16'sd146;  k.kb = 16'sd482;
        end else begin
          k.kr = 16'sd13806;  k.kg1 = -16'sd1541; k.kg2 = -16'sd5349; k.kb = 16'sd17615;
        end
      end
      MAT_BT601: begin
        if (full) begin
          k.kr = 16'sd359;    k.kg1 = -16'sd88;   k.kg2 = -16'sd183;  k.kb = 16'sd454;
        end else begin
          k.kr = 16'sd13126;  k.kg1 = -16'sd3222; k.kg2 = -16'sd6686; k.kb = 16'sd16591;
        end
      end
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

/* sv/y2r_cfg.sv */
module y2r_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [y2r_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [y2r_pkg::CfgDatW-1:0] cfg_data_i,
  output y2r_pkg::cfg_t               cfg_o
);

  y2r_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (y2r_pkg::reg_idx_e'(cfg_index_i))
        y2r_pkg::REG_MATRIX:   cfg_d.matrix     = y2r_pkg::matrix_e'(cfg_data_i[1:0]);
        y2r_pkg::REG_FULL:     cfg_d.full_swing = cfg_data_i[0];
        y2r_pkg::REG_SHIFT:    cfg_d.shift      = cfg_data_i[y2r_pkg::ShiftW-1:0];
        y2r_pkg::REG_SWAP:     cfg_d.swap_rb    = cfg_data_i[0];
        y2r_pkg::REG_ALPHA_EN: cfg_d.alpha_en   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matrix     <= y2r_pkg::MAT_BT601;
      cfg_q.full_swing <= 1'b0;
      cfg_q.shift      <= '0;
      cfg_q.swap_rb    <= 1'b0;
      cfg_q.alpha_en   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* sv/y2r_conv.sv */
module y2r_conv (
  input  y2r_pkg::cfg_t  cfg_i,
  input  y2r_pkg::pix_t  pix_i,
  output y2r_pkg::rgba_t rgba_o
);

  logic [15:0]        y_sh, cb_sh, cr_sh, a_sh;
  logic [7:0]         y_lim, cb_lim, cr_lim, y_off;
  logic signed [17:0] cbz, crz;
  logic signed [27:0] y_term, bias;
  logic signed [33:0] p_r, p_g1, p_g2, p_b;
  logic signed [27:0] sum_r, sum_g, sum_b;
  logic [7:0]         r, g, b;
  y2r_pkg::coef_t     k;

  function automatic logic [7:0] clamp_lim(logic [15:0] v, logic [7:0] hi);
    logic [7:0] res;
    if (v < 16'd16) begin
      res = 8'd16;
    end else if (v > {8'd0, hi}) begin
      res = hi;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] sat8(logic [15:0] v);
    return (|v[15:8]) ? 8'hFF : v[7:0];
  endfunction

  // floor shift then clamp to a byte
  function automatic logic [7:0] finish(logic signed [27:0] s, logic full);
    logic signed [27:0] q;
    logic [7:0]         res;
    q = full ? (s >>> 8) : (s >>> 13);
    if (q < 0) begin
      res = 8'd0;
    end else if (q > 28'sd255) begin
      res = 8'hFF;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

  assign y_sh  = pix_i.luma  >> cfg_i.shift;
  assign cb_sh = pix_i.cb    >> cfg_i.shift;
  assign cr_sh = pix_i.cr    >> cfg_i.shift;
  assign a_sh  = pix_i.alpha >> cfg_i.shift;

  assign y_lim  = clamp_lim(y_sh, 8'd235);
  assign cb_lim = clamp_lim(cb_sh, 8'd240);
  assign cr_lim = clamp_lim(cr_sh, 8'd240);
  assign y_off  = y_lim - 8'd16;

  assign k = y2r_pkg::coef_lookup(cfg_i.matrix, cfg_i.full_swing);

  always_comb begin
    if (cfg_i.full_swing) begin
      cbz    = $signed({2'b00, cb_sh}) - 18'sd128;
      crz    = $signed({2'b00, cr_sh}) - 18'sd128;
      // y*256 added before the shift is exact after the floor
      y_term = $signed({4'd0, y_sh, 8'd0});
      bias   = 28'sd128;
    end else begin
      cbz    = $signed({10'd0, cb_lim}) - 18'sd128;
      crz    = $signed({10'd0, cr_lim}) - 18'sd128;
      y_term = $signed({6'd0, {14'd0, y_off} * 22'd9576});
      bias   = 28'sd4096;
    end
  end

  assign p_r  = k.kr  * crz;
  assign p_g1 = k.kg1 * cbz;
  assign p_g2 = k.kg2 * crz;
  assign p_b  = k.kb  * cbz;

  assign sum_r = y_term + $signed(p_r[27:0]) + bias;
  assign sum_g = y_term + $signed(p_g1[27:0]) + $signed(p_g2[27:0]) + bias;
  assign sum_b = y_term + $signed(p_b[27:0]) + bias;

  always_comb begin
    if (cfg_i.matrix == y2r_pkg::MAT_GBR) begin
      r = sat8(cr_sh);
      g = sat8(y_sh);
      b = sat8(cb_sh);
    end else begin
      r = finish(sum_r, cfg_i.full_swing);
      g = finish(sum_g, cfg_i.full_swing);
      b = finish(sum_b, cfg_i.full_swing);
    end
  end

  assign rgba_o.first  = cfg_i.swap_rb ? b : r;
  assign rgba_o.second = g;
  assign rgba_o.third  = cfg_i.swap_rb ? r : b;
  assign rgba_o.fourth = (cfg_i.alpha_en && pix_i.alpha_present) ? a_sh[7:0] : 8'hFF;

endmodule

/* sv/ycbcr_to_rgb_pixel.sv */
// YCbCr (plus optional alpha) to packed 8-bit RGB/BGR, one pixel per item.
// Input channel: in_valid_i / in_stall_o with the luma, Cb, Cr, alpha samples
// and the alpha_present flag; an item is taken when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i with four bytes per item.
// Configuration: cfg_valid_i / cfg_ready_o with a register index and data;
// ready is always high. Write registers only while no item is in flight.
// Path: an accepted item is held in the input register, passes the conversion
// logic and is presented from the result register.
// Throughput: one item per cycle unless the output stalls; the conversion is
// one combinational pass: four coefficient multiplies, an add tree per channel.
// A stalled result holds in the result register while a further item can
// still be taken into the input register; in_stall_o rises only when both
// registers are full and the output is stalled.
// Reset clears both valid flags and sets the registers to BT.601, limited
// range, no shift, RGB order and alpha disabled.
module ycbcr_to_rgb_pixel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 luma_sample_i,
  input  logic [15:0]                 blue_diff_sample_i,
  input  logic [15:0]                 red_diff_sample_i,
  input  logic [15:0]                 alpha_sample_i,
  input  logic                        alpha_present_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  first_byte_o,
  output logic [7:0]                  second_byte_o,
  output logic [7:0]                  third_byte_o,
  output logic [7:0]                  fourth_byte_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [y2r_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [y2r_pkg::CfgDatW-1:0] cfg_data_i
);

  y2r_pkg::cfg_t  cfg;
  y2r_pkg::pix_t  pix_q;
  y2r_pkg::rgba_t rgba, rgba_q;
  logic           in_vld_d, in_vld_q, out_vld_d, out_vld_q;
  logic           out_adv, in_acc;

  y2r_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  y2r_conv u_conv (
    .cfg_i  (cfg),
    .pix_i  (pix_q),
    .rgba_o (rgba)
  );

  // result register frees up when empty or being taken
  assign out_adv    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (out_adv) begin
      out_vld_d = in_vld_q;
      in_vld_d  = 1'b0;
    end
    if (in_acc) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q.luma          <= luma_sample_i;
      pix_q.cb            <= blue_diff_sample_i;
      pix_q.cr            <= red_diff_sample_i;
      pix_q.alpha         <= alpha_sample_i;
      pix_q.alpha_present <= alpha_present_i;
    end
    if (out_adv && in_vld_q) begin
      rgba_q <= rgba;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign first_byte_o  = rgba_q.first;
  assign second_byte_o = rgba_q.second;
  assign third_byte_o  = rgba_q.third;
  assign fourth_byte_o = rgba_q.fourth;

endmodule
